[src/jecfs_pkg.sv]
package jecfs_pkg;

  typedef enum logic [2:0] {
    PH_KEY   = 3'd0,
    PH_COLON = 3'd1,
    PH_SPACE = 3'd2,
    PH_DIGIT = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  localparam logic [3:0] KEY_LEN = 4'd10;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [35:0] POS_LIMIT = 36'h07FFFFFFF;
  localparam logic [35:0] NEG_LIMIT = 36'h080000000;

  typedef struct packed {
    logic [31:0] code_value;
    logic        key_found;
    logic        overflowed;
  } result_t;

  // Characters of the quoted key, quotes included
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = CH_QUOTE;
      4'd1:    ch = 8'h65;
      4'd2:    ch = 8'h72;
      4'd3:    ch = 8'h72;
      4'd4:    ch = 8'h5F;
      4'd5:    ch = 8'h63;
      4'd6:    ch = 8'h6F;
      4'd7:    ch = 8'h64;
      4'd8:    ch = 8'h65;
      4'd9:    ch = CH_QUOTE;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[src/jecfs_dig_acc.sv]
module jecfs_dig_acc (
  input  logic [31:0] mag_in,
  input  logic [3:0]  digit,
  input  logic        minus,
  output logic [31:0] mag_out,
  output logic        sat
);

  logic [35:0] wide;
  logic [35:0] limit;

  // mag * 10 + digit as two shifted adds
  assign wide  = ({4'd0, mag_in} << 3) + ({4'd0, mag_in} << 1) + {32'd0, digit};
  assign limit = minus ? jecfs_pkg::NEG_LIMIT : jecfs_pkg::POS_LIMIT;

  always_comb begin
    if (wide > limit) begin
      mag_out = limit[31:0];
      sat     = 1'b1;
    end else begin
      mag_out = wide[31:0];
      sat     = 1'b0;
    end
  end

endmodule

[src/jecfs_scan.sv]
module jecfs_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          text_byte,
  input  logic                last_byte,
  output jecfs_pkg::result_t  result
);

  jecfs_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        minus_r, minus_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic        sat_r, sat_nxt;
  logic        key_r, key_nxt;

  logic [3:0]  p_cur;
  logic [3:0]  p_next;
  logic        is_digit;
  logic [31:0] acc_mag;
  logic        acc_sat;

  assign is_digit = (text_byte >= jecfs_pkg::CH_ZERO) && (text_byte <= jecfs_pkg::CH_NINE);
  assign p_cur    = (pos_r >= jecfs_pkg::KEY_LEN) ? 4'd0 : pos_r;

  jecfs_dig_acc u_dig_acc (
    .mag_in  (mag_r),
    .digit   (text_byte[3:0]),
    .minus   (minus_r),
    .mag_out (acc_mag),
    .sat     (acc_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      phase_r <= jecfs_pkg::PH_KEY;
      pos_r   <= 4'd0;
      minus_r <= 1'b0;
      mag_r   <= 32'd0;
      sat_r   <= 1'b0;
      key_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      minus_r <= minus_nxt;
      mag_r   <= mag_nxt;
      sat_r   <= sat_nxt;
      key_r   <= key_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    minus_nxt = minus_r;
    mag_nxt   = mag_r;
    sat_nxt   = sat_r;
    key_nxt   = key_r;
    p_next    = 4'd0;
    case (phase_r)
      jecfs_pkg::PH_KEY: begin
        // restart on a quote, since it can open the key
        if (text_byte == jecfs_pkg::key_char(p_cur)) begin
          p_next = p_cur + 4'd1;
        end else begin
          p_next = (text_byte == jecfs_pkg::CH_QUOTE) ? 4'd1 : 4'd0;
        end
        if (p_next >= jecfs_pkg::KEY_LEN) begin
          key_nxt   = 1'b1;
          phase_nxt = jecfs_pkg::PH_COLON;
          pos_nxt   = 4'd0;
        end else begin
          pos_nxt = p_next;
        end
      end
      jecfs_pkg::PH_COLON: begin
        if (text_byte == jecfs_pkg::CH_COLON) begin
          phase_nxt = jecfs_pkg::PH_SPACE;
        end
      end
      jecfs_pkg::PH_SPACE: begin
        if (text_byte == jecfs_pkg::CH_SPACE) begin
          phase_nxt = jecfs_pkg::PH_SPACE;
        end else if (text_byte == jecfs_pkg::CH_MINUS) begin
          minus_nxt = 1'b1;
          phase_nxt = jecfs_pkg::PH_DIGIT;
        end else if (is_digit) begin
          mag_nxt   = acc_mag;
          sat_nxt   = sat_r | acc_sat;
          phase_nxt = jecfs_pkg::PH_DIGIT;
        end else begin
          phase_nxt = jecfs_pkg::PH_DONE;
        end
      end
      jecfs_pkg::PH_DIGIT: begin
        if (is_digit) begin
          mag_nxt = acc_mag;
          sat_nxt = sat_r | acc_sat;
        end else begin
          phase_nxt = jecfs_pkg::PH_DONE;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // Result reflects the state after this byte
  assign result.code_value = minus_nxt ? (32'd0 - mag_nxt) : mag_nxt;
  assign result.key_found  = key_nxt;
  assign result.overflowed = sat_nxt;

endmodule

[src/json_err_code_field_scanner.sv]
// An accepted item passes through the input register, then the result register, to its
// result on out_valid. Throughput: one byte per cycle; the input register stalls only
// while it holds a last byte and the result register is still occupied.
// A result appears only for an item marked last_byte.
// Reset (rst_n low at a clock edge) clears the scan state and both valid flags;
// the scan state also clears after every last byte.
module json_err_code_field_scanner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_text_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_code_value,
  output logic               out_key_found,
  output logic               out_overflowed
);

  logic        hold_valid_r;
  logic [7:0]  hold_byte_r;
  logic        hold_last_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] code_r;
  logic        key_found_r;
  logic        ovf_r;

  logic        out_free;
  logic        step;
  jecfs_pkg::result_t scan_res;

  assign out_free = !out_valid_r || out_ready;
  // non-last bytes never need the result register
  assign step     = hold_valid_r && (!hold_last_r || out_free);
  assign in_ready = !hold_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte_r <= in_text_byte;
      hold_last_r <= in_last_byte;
    end
  end

  jecfs_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .text_byte (hold_byte_r),
    .last_byte (hold_last_r),
    .result    (scan_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && hold_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hold_last_r) begin
      code_r      <= scan_res.code_value;
      key_found_r <= scan_res.key_found;
      ovf_r       <= scan_res.overflowed;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_value = code_r;
  assign out_key_found  = key_found_r;
  assign out_overflowed = ovf_r;

  a_ovf_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!ovf_r || key_found_r))
    else $error("overflow reported without key");

  a_value_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((code_r == 32'd0) || key_found_r))
    else $error("nonzero value reported without key");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ovf_r) |-> ((code_r == 32'h7FFFFFFF) || (code_r == 32'h80000000)))
    else $error("overflowed value is not a limit");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (hold_valid_r && hold_last_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result dropped");

endmodule
